FILE: hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the hash map; the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst, pre, post, msg)
`define ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

FILE: hw/rtl/lphm_pkg.sv
// Shared types, codes and widths of the linear probing hash map.
package lphm_pkg;

   localparam int SLOTS_DEFAULT = 256;

   localparam int CMD_W   = 2;
   localparam int KEY_W   = 32;
   localparam int HASH_W  = 32;
   localparam int VALUE_W = 64;
   localparam int LIMIT_W = 9;

   localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RESET = 9'd192;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_LOAD_LIMIT = 1'b0;

   localparam logic [CMD_W-1:0] CMD_GET    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SET    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PROBE,
      ST_RCHK,
      ST_RPROBE,
      ST_RESP
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CLEAR,
      OP_ACCEPT,
      OP_PROBE_STEP,
      OP_UPDATE,
      OP_INSERT,
      OP_REMOVE,
      OP_RELOC_START,
      OP_RELOC_STEP,
      OP_RELOC_PLACE
   } op_type;

   typedef struct packed {
      op_type op;
      logic   res_set;
      logic   res_hit;
      logic   res_status;
      logic   res_take_value;
      logic   rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             req_nop;
      logic             key_match;
      logic             slot_empty;
      logic             probe_last;
      logic             room;
      logic             clr_last;
      logic             rem_last;
      logic             rsp_free;
   } dp_status_type;

endpackage

FILE: hw/rtl/linear_probe_hash_map.sv
// Top level of the linear probing hash map: CSR block, controller, datapath.
// Get and set probe from the home slot until they find the key, an empty slot or have seen
//   every slot; the slot store yields one slot per cycle.
// Remove then walks the cluster behind the freed slot and re-places each entry at the first
//   free slot from its home, until an empty slot ends the cluster.
// Throughput: one request at a time; the next beat is taken when the response is queued.
// Reset (synchronous, high): a clearing pass over every slot empties the slot store,
//   with req_stall high; load_limit returns to 192. SLOTS must be a power of two.
`include "assert_macros.svh"

module linear_probe_hash_map #(
   parameter int SLOTS = lphm_pkg::SLOTS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [lphm_pkg::CMD_W-1:0]       req_cmd,
   input  logic [lphm_pkg::KEY_W-1:0]       req_key_id,
   input  logic [lphm_pkg::HASH_W-1:0]      req_key_hash,
   input  logic [lphm_pkg::VALUE_W-1:0]     req_entry_value,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_hit,
   output logic [lphm_pkg::VALUE_W-1:0]     rsp_read_value,
   output logic                             rsp_status,
   // configuration port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [lphm_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [lphm_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [lphm_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import lphm_pkg::*;

   logic [LIMIT_W-1:0] load_limit_ff;
   logic               csr_hit_limit;
   dp_cmd_type         dp_cmd;
   dp_status_type      dp_status;

   // Register index is the word address; only load_limit exists.
   assign csr_hit_limit = (csr_paddr[CSR_ADDR_W-1:2] == CSR_IDX_LOAD_LIMIT);
   assign csr_pready    = 1'b1;

   // Take the write in the access phase; writes to other words are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         load_limit_ff <= LOAD_LIMIT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_hit_limit) begin
         load_limit_ff <= csr_pwdata[LIMIT_W-1:0];
      end
   end

   // Read back the limit, zero-extended; unmapped words read as zero.
   always_comb begin
      csr_prdata = '0;
      if (csr_hit_limit) begin
         csr_prdata = {{(CSR_DATA_W - LIMIT_W){1'b0}}, load_limit_ff};
      end
   end

   // Controller walks the state machine; datapath owns the slot store.
   lphm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   lphm_dp #(
      .SLOTS (SLOTS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_cmd         (req_cmd),
      .req_key_id      (req_key_id),
      .req_key_hash    (req_key_hash),
      .req_entry_value (req_entry_value),
      .load_limit      (load_limit_ff),
      .rsp_stall       (rsp_stall),
      .dp_cmd          (dp_cmd),
      .dp_status       (dp_status),
      .rsp_valid       (rsp_valid),
      .rsp_hit         (rsp_hit),
      .rsp_read_value  (rsp_read_value),
      .rsp_status      (rsp_status)
   );

   // A response load never overwrites a beat that is still stalled.
   `ASSERT_IMPLY(a_rsp_load_free, clock, reset, dp_cmd.rsp_load, dp_status.rsp_free, "response overwritten")
   // A loaded response shows up on the channel in the next cycle.
   `ASSERT_NEXT(a_rsp_load_shows, clock, reset, dp_cmd.rsp_load, rsp_valid, "response beat lost")
   // Insert only with room under the load limit.
   `ASSERT_IMPLY(a_insert_room, clock, reset, dp_cmd.op == OP_INSERT, dp_status.room, "insert over limit")

endmodule

FILE: hw/rtl/lphm_ctrl.sv
// Controller state machine: sequences clear, probe, update, insert, remove and reinsert steps.
module lphm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  lphm_pkg::dp_status_type dp_status,
   output lphm_pkg::dp_cmd_type    dp_cmd
);
   import lphm_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      dp_cmd    = '0;
      dp_cmd.op = OP_NONE;
      req_stall = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            dp_cmd.op = OP_CLEAR;
            if (dp_status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               dp_cmd.op = OP_ACCEPT;
               if (dp_status.req_nop) begin
                  dp_cmd.res_set = 1'b1;
                  state_in       = ST_RESP;
               end else begin
                  state_in = ST_PROBE;
               end
            end
         end
         ST_PROBE: begin
            dp_cmd.res_set = 1'b1;
            state_in       = ST_RESP;
            if (dp_status.key_match) begin
               case (dp_status.cmd)
                  CMD_GET: begin
                     dp_cmd.res_hit        = 1'b1;
                     dp_cmd.res_take_value = 1'b1;
                  end
                  CMD_SET: begin
                     dp_cmd.op = OP_UPDATE;
                  end
                  default: begin
                     dp_cmd.op      = OP_REMOVE;
                     dp_cmd.res_hit = 1'b1;
                     state_in       = ST_RCHK;
                  end
               endcase
            end else if (dp_status.slot_empty) begin
               if (dp_status.cmd == CMD_SET) begin
                  if (dp_status.room) begin
                     dp_cmd.op      = OP_INSERT;
                     dp_cmd.res_hit = 1'b1;
                  end else begin
                     dp_cmd.res_status = 1'b1;
                  end
               end
            end else if (dp_status.probe_last) begin
               if (dp_status.cmd == CMD_SET) begin
                  dp_cmd.res_status = 1'b1;
               end
            end else begin
               dp_cmd.res_set = 1'b0;
               dp_cmd.op      = OP_PROBE_STEP;
               state_in       = ST_PROBE;
            end
         end
         ST_RCHK: begin
            if (dp_status.slot_empty) begin
               state_in = ST_RESP;
            end else begin
               dp_cmd.op = OP_RELOC_START;
               state_in  = ST_RPROBE;
            end
         end
         ST_RPROBE: begin
            if (dp_status.slot_empty) begin
               dp_cmd.op = OP_RELOC_PLACE;
               state_in  = dp_status.rem_last ? ST_RESP : ST_RCHK;
            end else begin
               dp_cmd.op = OP_RELOC_STEP;
            end
         end
         ST_RESP: begin
            if (dp_status.rsp_free) begin
               dp_cmd.rsp_load = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: hw/rtl/lphm_dp.sv
// Datapath: slot store, probe indexes, live count, result and output registers.
module lphm_dp #(
   parameter int SLOTS = lphm_pkg::SLOTS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [lphm_pkg::CMD_W-1:0]     req_cmd,
   input  logic [lphm_pkg::KEY_W-1:0]     req_key_id,
   input  logic [lphm_pkg::HASH_W-1:0]    req_key_hash,
   input  logic [lphm_pkg::VALUE_W-1:0]   req_entry_value,
   input  logic [lphm_pkg::LIMIT_W-1:0]   load_limit,
   input  logic                           rsp_stall,
   input  lphm_pkg::dp_cmd_type           dp_cmd,
   output lphm_pkg::dp_status_type        dp_status,
   output logic                           rsp_valid,
   output logic                           rsp_hit,
   output logic [lphm_pkg::VALUE_W-1:0]   rsp_read_value,
   output logic                           rsp_status
);
   import lphm_pkg::*;

   localparam int IW = $clog2(SLOTS);
   localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
   localparam logic [IW-1:0] REM_LAST = IW'(SLOTS - 2);

   logic [KEY_W-1:0]   mem_key   [SLOTS];
   logic [IW-1:0]      mem_home  [SLOTS];
   logic [VALUE_W-1:0] mem_value [SLOTS];

   logic [KEY_W-1:0]   rd_key_ff;
   logic [IW-1:0]      rd_home_ff;
   logic [VALUE_W-1:0] rd_value_ff;

   logic               we;
   logic [IW-1:0]      wr_addr;
   logic [IW-1:0]      rd_addr;
   logic [KEY_W-1:0]   wr_key;
   logic [IW-1:0]      wr_home;
   logic [VALUE_W-1:0] wr_value;

   logic [CMD_W-1:0]   cmd_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [IW-1:0]      home_ff;
   logic [VALUE_W-1:0] value_ff;

   logic [IW-1:0]      idx_ff, idx_in;
   logic [IW-1:0]      cnt_ff, cnt_in;
   logic [IW-1:0]      ri_ff, ri_in;
   logic [IW-1:0]      rcnt_ff, rcnt_in;
   logic [LIMIT_W-1:0] live_ff, live_in;

   logic [KEY_W-1:0]   mv_key_ff;
   logic [IW-1:0]      mv_home_ff;
   logic [VALUE_W-1:0] mv_value_ff;

   logic               res_hit_ff;
   logic               res_status_ff;
   logic [VALUE_W-1:0] res_value_ff;

   logic               rsp_valid_ff;
   logic               rsp_hit_ff;
   logic               rsp_status_ff;
   logic [VALUE_W-1:0] rsp_value_ff;

   logic [IW-1:0]      home_now;

   assign home_now = req_key_hash[IW-1:0];

   always_comb begin
      rd_addr  = idx_ff;
      we       = 1'b0;
      wr_addr  = idx_ff;
      wr_key   = '0;
      wr_home  = '0;
      wr_value = '0;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      ri_in    = ri_ff;
      rcnt_in  = rcnt_ff;
      live_in  = live_ff;
      case (dp_cmd.op)
         OP_CLEAR: begin
            we     = 1'b1;
            idx_in = idx_ff + 1'b1;
         end
         OP_ACCEPT: begin
            rd_addr = home_now;
            idx_in  = home_now;
            cnt_in  = '0;
         end
         OP_PROBE_STEP: begin
            rd_addr = idx_ff + 1'b1;
            idx_in  = idx_ff + 1'b1;
            cnt_in  = cnt_ff + 1'b1;
         end
         OP_UPDATE: begin
            we       = 1'b1;
            wr_key   = rd_key_ff;
            wr_home  = rd_home_ff;
            wr_value = value_ff;
         end
         OP_INSERT: begin
            we       = 1'b1;
            wr_key   = key_ff;
            wr_home  = home_ff;
            wr_value = value_ff;
            live_in  = live_ff + 1'b1;
         end
         OP_REMOVE: begin
            we      = 1'b1;
            rd_addr = idx_ff + 1'b1;
            ri_in   = idx_ff + 1'b1;
            rcnt_in = '0;
            if (live_ff != '0) begin
               live_in = live_ff - 1'b1;
            end
         end
         OP_RELOC_START: begin
            we      = 1'b1;
            wr_addr = ri_ff;
            rd_addr = rd_home_ff;
            idx_in  = rd_home_ff;
         end
         OP_RELOC_STEP: begin
            rd_addr = idx_ff + 1'b1;
            idx_in  = idx_ff + 1'b1;
         end
         OP_RELOC_PLACE: begin
            we       = 1'b1;
            wr_key   = mv_key_ff;
            wr_home  = mv_home_ff;
            wr_value = mv_value_ff;
            rd_addr  = ri_ff + 1'b1;
            ri_in    = ri_ff + 1'b1;
            rcnt_in  = rcnt_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Write-first read port: a read of the slot being written sees the new entry.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_key[wr_addr]   <= wr_key;
         mem_home[wr_addr]  <= wr_home;
         mem_value[wr_addr] <= wr_value;
      end
      if (we && (wr_addr == rd_addr)) begin
         rd_key_ff   <= wr_key;
         rd_home_ff  <= wr_home;
         rd_value_ff <= wr_value;
      end else begin
         rd_key_ff   <= mem_key[rd_addr];
         rd_home_ff  <= mem_home[rd_addr];
         rd_value_ff <= mem_value[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff  <= idx_in;
         live_ff <= live_in;
         if (dp_cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      ri_ff   <= ri_in;
      rcnt_ff <= rcnt_in;
      if (dp_cmd.op == OP_ACCEPT) begin
         cmd_ff   <= req_cmd;
         key_ff   <= req_key_id;
         home_ff  <= home_now;
         value_ff <= req_entry_value;
      end
      if (dp_cmd.op == OP_RELOC_START) begin
         mv_key_ff   <= rd_key_ff;
         mv_home_ff  <= rd_home_ff;
         mv_value_ff <= rd_value_ff;
      end
      if (dp_cmd.res_set) begin
         res_hit_ff    <= dp_cmd.res_hit;
         res_status_ff <= dp_cmd.res_status;
         res_value_ff  <= dp_cmd.res_take_value ? rd_value_ff : '0;
      end
      if (dp_cmd.rsp_load) begin
         rsp_hit_ff    <= res_hit_ff;
         rsp_status_ff <= res_status_ff;
         rsp_value_ff  <= res_value_ff;
      end
   end

   always_comb begin
      dp_status.cmd        = cmd_ff;
      dp_status.req_nop    = (req_key_id == '0) ||
                             !(req_cmd inside {CMD_GET, CMD_SET, CMD_REMOVE});
      dp_status.key_match  = (rd_key_ff == key_ff);
      dp_status.slot_empty = (rd_key_ff == '0);
      dp_status.probe_last = (cnt_ff == LAST_IDX);
      dp_status.room       = (live_ff < load_limit);
      dp_status.clr_last   = (idx_ff == LAST_IDX);
      dp_status.rem_last   = (rcnt_ff == REM_LAST);
      dp_status.rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_value_ff;

endmodule
